// ===== sv/sptt_pkg.sv =====
// shared types and constants for the sparse polynomial term table
`timescale 1ns / 1ps
`default_nettype none
package sptt_pkg;
   localparam int COEF_W = 32;
   localparam int EXP_W  = 6;
   localparam int STAT_W = 3;
   localparam int CNT_W  = 5;

   localparam logic [STAT_W-1:0] ST_ZERO    = 3'd0;
   localparam logic [STAT_W-1:0] ST_INSERT  = 3'd1;
   localparam logic [STAT_W-1:0] ST_MERGE   = 3'd2;
   localparam logic [STAT_W-1:0] ST_REMOVE  = 3'd3;
   localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;
   localparam logic [STAT_W-1:0] ST_EVAL    = 3'd5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_EVAL   = 1'b1;

   localparam logic signed [COEF_W-1:0] Q_ONE = 32'sh0001_0000;

   // commands from controller to datapath
   typedef struct packed {
      logic load;       // capture request
      logic scan_rd;    // read entry at scan index
      logic scan_inc;   // advance scan index
      logic merge_wr;   // write merged coefficient
      logic mark;       // keep insertion position, index to count
      logic shift_up;   // move one entry up (insert)
      logic shift_dn;   // move one entry down (remove)
      logic place;      // write new term at position
      logic pw_init;    // power := 1.0
      logic pw_mul;     // power := power * x
      logic term_mul;   // product := coef * power
      logic acc_add;    // acc += product
      logic cnt_inc;
      logic cnt_dec;
      logic rsp;        // present result
      logic [STAT_W-1:0] status;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic op_eval;
      logic coef_zero;
      logic scan_end;   // index reached count
      logic exp_greater;
      logic exp_equal;
      logic sum_zero;
      logic full;
      logic pw_done;    // power step count reached exponent
      logic shift_done;
      logic at_pos;     // index back at insertion position
   } sts_type;
endpackage
`default_nettype wire

// ===== sv/sptt_datapath.sv =====
// datapath: term tables, scan index, multiplier, accumulator
`timescale 1ns / 1ps
`default_nettype none
module sptt_datapath import sptt_pkg::*; #(
   parameter int MAX_TERMS    = 16,
   parameter int MAX_EXPONENT = 63,
   parameter int IDX_W        = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   output sts_type                       sts,
   input  wire logic                     req_operation,
   input  wire logic signed [COEF_W-1:0] req_term_coefficient,
   input  wire logic [EXP_W-1:0]         req_term_exponent,
   input  wire logic signed [COEF_W-1:0] req_eval_point,
   output logic                          rsp_valid,
   output logic [STAT_W-1:0]             rsp_status,
   output logic [CNT_W-1:0]              rsp_stored_terms,
   output logic signed [COEF_W-1:0]      rsp_poly_value,
   output logic                          rsp_overflowed
);
   logic [EXP_W-1:0]         exp_mem [MAX_TERMS];
   logic signed [COEF_W-1:0] coef_mem [MAX_TERMS];

   logic                     op_ff;
   logic signed [COEF_W-1:0] c_ff, x_ff;
   logic [EXP_W-1:0]         e_ff;
   logic [IDX_W:0]           idx_ff, idx_in, cnt_ff, cnt_in, pos_ff;
   logic [EXP_W-1:0]         re_ff, k_ff;
   logic signed [COEF_W-1:0] rc_ff, pw_ff, prod_ff, acc_ff;
   logic                     ovf_ff;
   logic                     vld_ff;
   logic [STAT_W-1:0]        st_ff;
   logic signed [COEF_W-1:0] val_ff;

   // exponent clamp
   logic [EXP_W-1:0] e_clamp;
   always_comb begin
      if (32'(req_term_exponent) > MAX_EXPONENT) e_clamp = EXP_W'(MAX_EXPONENT);
      else                                       e_clamp = req_term_exponent;
   end

   // shared q16.16 multiplier, floor shift then saturate
   logic signed [COEF_W-1:0] ma, mb, mq;
   logic signed [63:0]       mp, mf;
   logic                     movf;
   always_comb begin
      ma = cmd.pw_mul ? pw_ff : rc_ff;
      mb = cmd.pw_mul ? x_ff  : pw_ff;
      mp = 64'(ma) * 64'(mb);
      mf = mp >>> 16;
      movf = 1'b0;
      if (mf > 64'sd2147483647) begin
         mq = 32'sh7fff_ffff; movf = 1'b1;
      end else if (mf < -64'sd2147483648) begin
         mq = 32'sh8000_0000; movf = 1'b1;
      end else mq = mf[COEF_W-1:0];
   end

   // saturating adder for merge and accumulation
   logic signed [COEF_W-1:0] aa, ab, sq;
   logic signed [COEF_W:0]   sw;
   logic                     sovf;
   always_comb begin
      aa = cmd.acc_add ? acc_ff : rc_ff;
      ab = cmd.acc_add ? prod_ff : c_ff;
      sw = {aa[COEF_W-1], aa} + {ab[COEF_W-1], ab};
      sovf = sw[COEF_W] != sw[COEF_W-1];
      if (sovf) sq = sw[COEF_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      else      sq = sw[COEF_W-1:0];
   end

   logic [IDX_W-1:0] ia, im1;
   assign ia  = idx_ff[IDX_W-1:0];
   assign im1 = IDX_W'(idx_ff - 1'b1);

   // index and count
   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) idx_in = '0;
      if (cmd.mark) idx_in = cnt_ff;
      if (cmd.scan_inc) idx_in = idx_ff + 1'b1;
      if (cmd.shift_up) idx_in = idx_ff - 1'b1;
      if (cmd.shift_dn) idx_in = idx_ff + 1'b1;
      cnt_in = cnt_ff;
      if (cmd.cnt_inc) cnt_in = cnt_ff + 1'b1;
      if (cmd.cnt_dec) cnt_in = cnt_ff - 1'b1;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; idx_ff <= '0; vld_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         vld_ff <= cmd.rsp;
      end
   end

   // payload registers and tables
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_operation; c_ff <= req_term_coefficient;
         e_ff <= e_clamp; x_ff <= req_eval_point;
         acc_ff <= '0; ovf_ff <= 1'b0;
      end
      if (cmd.mark) pos_ff <= idx_ff;
      if (cmd.scan_rd) begin
         re_ff <= exp_mem[ia]; rc_ff <= coef_mem[ia];
      end
      if (cmd.merge_wr) begin
         if (sovf) ovf_ff <= 1'b1;
         if (sq != 0) coef_mem[ia] <= sq;
      end
      if (cmd.shift_up) begin
         exp_mem[ia] <= exp_mem[im1]; coef_mem[ia] <= coef_mem[im1];
      end
      if (cmd.shift_dn) begin
         exp_mem[ia] <= exp_mem[IDX_W'(idx_ff + 1'b1)];
         coef_mem[ia] <= coef_mem[IDX_W'(idx_ff + 1'b1)];
      end
      if (cmd.place) begin
         exp_mem[ia] <= e_ff; coef_mem[ia] <= c_ff;
      end
      if (cmd.pw_init) begin
         pw_ff <= Q_ONE; k_ff <= '0;
      end
      if (cmd.pw_mul) begin
         pw_ff <= mq; k_ff <= k_ff + 1'b1;
         if (movf) ovf_ff <= 1'b1;
      end
      if (cmd.term_mul) begin
         prod_ff <= mq;
         if (movf) ovf_ff <= 1'b1;
      end
      if (cmd.acc_add) begin
         acc_ff <= sq;
         if (sovf) ovf_ff <= 1'b1;
      end
      if (cmd.rsp) begin
         st_ff  <= cmd.status;
         val_ff <= op_ff ? acc_ff : '0;
      end
   end

   // status to controller
   always_comb begin
      sts.op_eval     = op_ff;
      sts.coef_zero   = c_ff == 0;
      sts.scan_end    = idx_ff >= cnt_ff;
      sts.exp_greater = re_ff > e_ff;
      sts.exp_equal   = re_ff == e_ff;
      sts.sum_zero    = sq == 0;
      sts.full        = 32'(cnt_ff) >= MAX_TERMS;
      sts.pw_done     = k_ff == re_ff;
      sts.shift_done  = 32'(idx_ff) + 1 >= 32'(cnt_ff);
      sts.at_pos      = idx_ff == pos_ff;
   end

   assign rsp_valid        = vld_ff;
   assign rsp_status       = st_ff;
   assign rsp_stored_terms = CNT_W'(cnt_ff);
   assign rsp_poly_value   = val_ff;
   assign rsp_overflowed   = ovf_ff;
endmodule
`default_nettype wire

// ===== sv/sptt_ctrl.sv =====
// controller state machine sequencing insert and evaluate
`timescale 1ns / 1ps
`default_nettype none
module sptt_ctrl import sptt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   output cmd_type      cmd,
   input  wire sts_type sts
);
   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_DEC   = 10'b0000000010,
      S_READ  = 10'b0000000100,
      S_CMP   = 10'b0000001000,
      S_SHUP  = 10'b0000010000,
      S_SHDN  = 10'b0000100000,
      S_PW    = 10'b0001000000,
      S_TERM  = 10'b0010000000,
      S_ACC   = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [STAT_W-1:0] st_ff, st_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; st_ff <= ST_ZERO;
      end else begin
         state_ff <= state_in; st_ff <= st_in;
      end
   end

   assign busy = state_ff != S_IDLE;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      cmd      = '0;
      cmd.status = st_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1; state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (!sts.op_eval && sts.coef_zero) begin
               st_in = ST_ZERO; state_in = S_DONE;
            end else state_in = S_READ;
         end
         S_READ: begin
            if (sts.scan_end) begin
               if (sts.op_eval) begin
                  st_in = ST_EVAL; state_in = S_DONE;
               end else if (sts.full) begin
                  st_in = ST_FULL; state_in = S_DONE;
               end else begin
                  // new lowest exponent goes straight in at the end
                  cmd.mark = 1'b1; st_in = ST_INSERT; state_in = S_SHUP;
               end
            end else begin
               cmd.scan_rd = 1'b1;
               state_in = sts.op_eval ? S_PW : S_CMP;
               if (sts.op_eval) cmd.pw_init = 1'b1;
            end
         end
         S_CMP: begin
            if (sts.exp_greater) begin
               cmd.scan_inc = 1'b1; state_in = S_READ;
            end else if (sts.exp_equal) begin
               if (sts.sum_zero) begin
                  cmd.merge_wr = 1'b0; st_in = ST_REMOVE; state_in = S_SHDN;
                  cmd.rsp = 1'b0;
                  // ovf impossible when sum is zero
               end else begin
                  cmd.merge_wr = 1'b1; st_in = ST_MERGE; state_in = S_DONE;
               end
            end else if (sts.full) begin
               st_in = ST_FULL; state_in = S_DONE;
            end else begin
               cmd.mark = 1'b1; st_in = ST_INSERT; state_in = S_SHUP;
            end
         end
         S_SHUP: begin
            // shift entries up from the top down to the insertion point
            if (sts.at_pos) begin
               cmd.place = 1'b1; cmd.cnt_inc = 1'b1; state_in = S_DONE;
            end else cmd.shift_up = 1'b1;
         end
         S_SHDN: begin
            if (sts.shift_done) begin
               cmd.cnt_dec = 1'b1; state_in = S_DONE;
            end else cmd.shift_dn = 1'b1;
         end
         S_PW: begin
            if (sts.pw_done) state_in = S_TERM;
            else cmd.pw_mul = 1'b1;
         end
         S_TERM: begin
            cmd.term_mul = 1'b1; state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc_add = 1'b1; cmd.scan_inc = 1'b1; state_in = S_READ;
         end
         S_DONE: begin
            cmd.rsp = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp |=> !busy) else $error("busy after result");
   a_noload: assert property (@(posedge clock) disable iff (reset)
      busy |-> !cmd.load) else $error("load while busy");
endmodule
`default_nettype wire

// ===== sv/sparse_polynomial_term_table.sv =====
// top level of the sparse polynomial term table
// evaluate forms each power and term product on the one shared multiplier, then accumulates the term
// one item at a time; busy drops in the strobe cycle, so the next transfer may meet the strobe
// results cannot be stalled; rsp_valid is high for one cycle
// synchronous reset empties the table; the term arrays themselves are not cleared
`timescale 1ns / 1ps
`default_nettype none
module sparse_polynomial_term_table import sptt_pkg::*; #(
   parameter int MAX_TERMS    = 16,
   parameter int MAX_EXPONENT = 63
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic                     req_operation,
   input  wire logic signed [COEF_W-1:0] req_term_coefficient,
   input  wire logic [EXP_W-1:0]         req_term_exponent,
   input  wire logic signed [COEF_W-1:0] req_eval_point,
   output logic                          rsp_valid,
   output logic [STAT_W-1:0]             rsp_status,
   output logic [CNT_W-1:0]              rsp_stored_terms,
   output logic signed [COEF_W-1:0]      rsp_poly_value,
   output logic                          rsp_overflowed
);
   localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   cmd_type cmd;
   sts_type sts;

   sptt_ctrl u_ctrl (.clock, .reset, .start, .busy, .cmd, .sts);

   sptt_datapath #(.MAX_TERMS(MAX_TERMS), .MAX_EXPONENT(MAX_EXPONENT), .IDX_W(IDX_W))
   u_dp (
      .clock, .reset, .cmd, .sts,
      .req_operation, .req_term_coefficient, .req_term_exponent, .req_eval_point,
      .rsp_valid, .rsp_status, .rsp_stored_terms, .rsp_poly_value, .rsp_overflowed
   );
endmodule
`default_nettype wire

// ===== sim/sparse_polynomial_term_table_tb.sv =====
// self-checking testbench for the sparse polynomial term table
`timescale 1ns / 1ps
`default_nettype none
module sparse_polynomial_term_table_tb;
   import sptt_pkg::*;

   localparam int TERM_CAP  = 16;
   localparam int EXP_TOP   = 63;
   localparam int CYCLE_CAP = 2000000;

   typedef struct {
      logic [STAT_W-1:0]        status;
      logic [CNT_W-1:0]         terms;
      logic signed [COEF_W-1:0] value;
      logic                     ovf;
   } poly_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic req_operation = OP_INSERT;
   logic signed [COEF_W-1:0] req_term_coefficient = '0;
   logic [EXP_W-1:0]         req_term_exponent = '0;
   logic signed [COEF_W-1:0] req_eval_point = '0;
   wire                      busy;
   wire                      rsp_valid;
   wire [STAT_W-1:0]         rsp_status;
   wire [CNT_W-1:0]          rsp_stored_terms;
   wire signed [COEF_W-1:0]  rsp_poly_value;
   wire                      rsp_overflowed;

   sparse_polynomial_term_table u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_term_coefficient(req_term_coefficient),
      .req_term_exponent(req_term_exponent), .req_eval_point(req_eval_point),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_stored_terms(rsp_stored_terms), .rsp_poly_value(rsp_poly_value),
      .rsp_overflowed(rsp_overflowed)
   );

   always #1 clock = ~clock;

   // predictor copy of the term table
   logic [EXP_W-1:0]         shadow_exp [TERM_CAP];
   logic signed [COEF_W-1:0] shadow_coef [TERM_CAP];
   int                       shadow_count = 0;

   poly_result_type expected_results [$];
   int mismatches = 0;
   int results_seen = 0;
   int items_sent = 0;
   int evals_sent = 0;
   longint cycle_count = 0;

   // saturate to 32 bits, flagging overflow
   function automatic logic signed [31:0] clamp32(longint v, inout logic ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return 32'sh7fff_ffff;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // q16.16 multiply with floor rounding
   function automatic logic signed [31:0] fix_mul(logic signed [31:0] a,
                                                  logic signed [31:0] b, inout logic ovf);
      longint p;
      p = longint'(a) * longint'(b);
      return clamp32(p >>> 16, ovf);
   endfunction

   // apply one item to the shadow table and return its result
   function automatic poly_result_type predict_term_item(logic op, logic signed [31:0] c,
                                                        logic [5:0] e, logic signed [31:0] x);
      poly_result_type r;
      logic ovf;
      int pos;
      logic signed [31:0] s, pw, acc;
      ovf = 1'b0;
      r.value = '0;
      if (op == OP_INSERT) begin
         if (c == 0) begin
            r.status = ST_ZERO;
         end else begin
            pos = 0;
            while (pos < shadow_count && shadow_exp[pos] > e) pos++;
            if (pos < shadow_count && shadow_exp[pos] == e) begin
               s = clamp32(longint'(shadow_coef[pos]) + longint'(c), ovf);
               if (s == 0) begin
                  for (int i = pos; i + 1 < shadow_count; i++) begin
                     shadow_exp[i] = shadow_exp[i+1];
                     shadow_coef[i] = shadow_coef[i+1];
                  end
                  shadow_count--;
                  r.status = ST_REMOVE;
               end else begin
                  shadow_coef[pos] = s;
                  r.status = ST_MERGE;
               end
            end else if (shadow_count >= TERM_CAP) begin
               r.status = ST_FULL;
            end else begin
               for (int i = shadow_count; i > pos; i--) begin
                  shadow_exp[i] = shadow_exp[i-1];
                  shadow_coef[i] = shadow_coef[i-1];
               end
               shadow_exp[pos] = e;
               shadow_coef[pos] = c;
               shadow_count++;
               r.status = ST_INSERT;
            end
         end
      end else begin
         acc = '0;
         for (int i = 0; i < shadow_count; i++) begin
            pw = Q_ONE;
            for (int k = 0; k < shadow_exp[i]; k++) pw = fix_mul(pw, x, ovf);
            acc = clamp32(longint'(acc) + longint'(fix_mul(shadow_coef[i], pw, ovf)), ovf);
         end
         r.value = acc;
         r.status = ST_EVAL;
      end
      r.terms = shadow_count[CNT_W-1:0];
      r.ovf = ovf;
      return r;
   endfunction

   // send one item after a random gap, holding start until the transfer
   task automatic send_term_item(logic op, logic signed [31:0] c, logic [5:0] e,
                                 logic signed [31:0] x);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_term_coefficient <= c;
      req_term_exponent <= e;
      req_eval_point <= x;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_results.push_back(predict_term_item(op, c, e, x));
      items_sent++;
      if (op == OP_EVAL) evals_sent++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // random coefficient leaning on small values and extremes
   function automatic logic signed [31:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $urandom;
         3: return 0;
         default: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
      endcase
   endfunction

   function automatic logic signed [31:0] pick_point();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 0;
         default: return $signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      poly_result_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result status %0d", rsp_status);
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status || rsp_stored_terms !== want.terms ||
                rsp_poly_value !== want.value || rsp_overflowed !== want.ovf) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected st %0d n %0d v %h o %b, got %0d %0d %h %b",
                           want.status, want.terms, want.value, want.ovf, rsp_status,
                           rsp_stored_terms, rsp_poly_value, rsp_overflowed);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("sparse_polynomial_term_table test failed");
         $finish;
      end
   end

   // field extremes, every status and the empty table
   task automatic test_directed();
      send_term_item(OP_EVAL, 0, 0, 32'sh7fff_ffff);
      send_term_item(OP_INSERT, 0, 6'd5, 0);
      send_term_item(OP_INSERT, 32'sh7fff_ffff, 6'd63, 32'shffff_ffff);
      send_term_item(OP_INSERT, 32'sh0001_0000, 6'd63, 0);
      send_term_item(OP_INSERT, 32'sh8000_0000, 6'd0, 0);
      send_term_item(OP_INSERT, 32'sh8000_0000, 6'd0, 0);
      send_term_item(OP_INSERT, 32'sh0002_0000, 6'd1, 0);
      send_term_item(OP_EVAL, 0, 0, 0);
      send_term_item(OP_EVAL, 0, 0, 32'sh8000_0000);
      send_term_item(OP_EVAL, 32'shffff_ffff, 6'h3f, 32'sh0000_8000);
      send_term_item(OP_INSERT, 32'sh8000_0001, 6'd63, 0);
      send_term_item(OP_INSERT, 32'shfffe_0000, 6'd1, 0);
      send_term_item(OP_INSERT, 32'sh7fff_ffff, 6'd0, 0);
      send_term_item(OP_EVAL, 0, 0, 32'sh0001_0000);
      // fill the table, then one more new exponent
      for (int i = 0; i < 17; i++) send_term_item(OP_INSERT, 32'sh0000_4000, 6'(i * 3), 0);
      send_term_item(OP_EVAL, 0, 0, 32'shffff_0000);
      drain_results();
   endtask

   // empty the table by removing every term; the most negative one takes two steps
   task automatic clear_table();
      while (shadow_count > 0)
         send_term_item(OP_INSERT,
                        shadow_coef[0] == 32'sh8000_0000 ? 32'sh7fff_ffff : -shadow_coef[0],
                        shadow_exp[0], 0);
   endtask

   // random builds of a polynomial with evaluations between
   task automatic test_random_polynomials();
      int narrow;
      for (int round = 0; round < 14; round++) begin
         clear_table();
         narrow = $urandom_range(4, 63);
         for (int n = 0; n < 22; n++) begin
            if ($urandom_range(0, 4) == 0)
               send_term_item(OP_EVAL, $urandom, 6'($urandom), pick_point());
            else
               send_term_item(OP_INSERT, pick_coef(), 6'($urandom_range(0, narrow)), $urandom);
         end
         // pause until the block has caught up
         if (round == 5) drain_results();
      end
      drain_results();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_polynomials();
      $display("covered %0d items including %0d evaluations, %0d results checked",
               items_sent, evals_sent, results_seen);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("sparse_polynomial_term_table test passed");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
         $display("sparse_polynomial_term_table test failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
sv/sptt_pkg.sv
sv/sptt_datapath.sv
sv/sptt_ctrl.sv
sv/sparse_polynomial_term_table.sv
sim/sparse_polynomial_term_table_tb.sv
